### sv/nfc_pkg.sv
// ----------------------------------------------------------------------------
// nfc_pkg
// Types and constants shared by the NOR flash command model.
// ----------------------------------------------------------------------------
package nfc_pkg;

  localparam int ADDR_W = 17;
  localparam int DATA_W = 8;
  localparam int PROG_TICKS_W = 16;
  localparam int TICKS_W = 20;

  localparam logic [1:0] OP_READ  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_TICK  = 2'd2;

  localparam logic [1:0] REG_PROGRAM_TICKS = 2'd0;
  localparam logic [1:0] REG_ERASE_TICKS   = 2'd1;
  localparam logic [1:0] REG_MAKER_CODE    = 2'd2;
  localparam logic [1:0] REG_PART_CODE     = 2'd3;

  localparam logic [14:0] UNLOCK_ADDR_1 = 15'h5555;
  localparam logic [14:0] UNLOCK_ADDR_2 = 15'h2AAA;

  localparam logic [DATA_W-1:0] CMD_UNLOCK_1  = 8'hAA;
  localparam logic [DATA_W-1:0] CMD_UNLOCK_2  = 8'h55;
  localparam logic [DATA_W-1:0] CMD_ID_ENTRY  = 8'h90;
  localparam logic [DATA_W-1:0] CMD_ID_EXIT   = 8'hF0;
  localparam logic [DATA_W-1:0] CMD_ERASE_SET = 8'h80;
  localparam logic [DATA_W-1:0] CMD_CHIP_ERASE = 8'h10;
  localparam logic [DATA_W-1:0] CMD_PROGRAM   = 8'hA0;
  localparam logic [DATA_W-1:0] ERASED_BYTE   = 8'hFF;

  localparam logic [PROG_TICKS_W-1:0] PROGRAM_TICKS_RST = 16'd20;
  localparam logic [TICKS_W-1:0]      ERASE_TICKS_RST   = 20'd1000;
  localparam logic [DATA_W-1:0]       MAKER_CODE_RST    = 8'hBF;
  localparam logic [DATA_W-1:0]       PART_CODE_RST     = 8'hB5;

  typedef enum logic [6:0] {
    STEP_IDLE     = 7'b0000001,
    STEP_AA       = 7'b0000010,
    STEP_55       = 7'b0000100,
    STEP_PROG     = 7'b0001000,
    STEP_ERASE    = 7'b0010000,
    STEP_ERASE_AA = 7'b0100000,
    STEP_ERASE_55 = 7'b1000000
  } unlock_step_t;

  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_IDLE  = 3'b010,
    ST_EXEC  = 3'b100
  } seq_state_t;

  typedef struct packed {
    logic              cell_we;
    logic [DATA_W-1:0] cell_wdata;
    logic              erase;
  } cell_action_t;

endpackage

### sv/nfc_ram.sv
// ----------------------------------------------------------------------------
// nfc_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module nfc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### sv/nfc_cmd.sv
// ----------------------------------------------------------------------------
// nfc_cmd
// Command decoder: unlock sequence, ID mode, busy timer and config registers.
// ----------------------------------------------------------------------------
module nfc_cmd (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [1:0]                         cfg_index,
  input  logic [nfc_pkg::TICKS_W-1:0]        cfg_data,
  input  logic                               exec,
  input  logic [1:0]                         opcode,
  input  logic [nfc_pkg::ADDR_W-1:0]         address,
  input  logic [nfc_pkg::DATA_W-1:0]         write_data,
  input  logic [nfc_pkg::DATA_W-1:0]         cell_q,
  output nfc_pkg::cell_action_t              action,
  output logic [nfc_pkg::DATA_W-1:0]         read_data,
  output logic                               busy_res
);

  logic [nfc_pkg::PROG_TICKS_W-1:0] program_ticks;
  logic [nfc_pkg::TICKS_W-1:0]      erase_ticks;
  logic [nfc_pkg::DATA_W-1:0]       maker_code;
  logic [nfc_pkg::DATA_W-1:0]       part_code;

  nfc_pkg::unlock_step_t      unlock_step, unlock_step_next;
  logic                       id_mode, id_mode_next;
  logic [nfc_pkg::TICKS_W-1:0] busy_left, busy_left_next;
  logic                       poll_bit, poll_bit_next;

  logic busy_now;
  logic at5;
  logic at2;

  assign busy_now = (busy_left != '0);
  assign at5 = (address[14:0] == nfc_pkg::UNLOCK_ADDR_1);
  assign at2 = (address[14:0] == nfc_pkg::UNLOCK_ADDR_2);

  always_ff @(posedge clk) begin
    if (rst) begin
      program_ticks <= nfc_pkg::PROGRAM_TICKS_RST;
      erase_ticks   <= nfc_pkg::ERASE_TICKS_RST;
      maker_code    <= nfc_pkg::MAKER_CODE_RST;
      part_code     <= nfc_pkg::PART_CODE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        nfc_pkg::REG_PROGRAM_TICKS: program_ticks <= cfg_data[nfc_pkg::PROG_TICKS_W-1:0];
        nfc_pkg::REG_ERASE_TICKS:   erase_ticks   <= cfg_data;
        nfc_pkg::REG_MAKER_CODE:    maker_code    <= cfg_data[nfc_pkg::DATA_W-1:0];
        nfc_pkg::REG_PART_CODE:     part_code     <= cfg_data[nfc_pkg::DATA_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unlock_step_next  = unlock_step;
    id_mode_next      = id_mode;
    busy_left_next    = busy_left;
    poll_bit_next     = poll_bit;
    action.cell_we    = 1'b0;
    action.cell_wdata = cell_q & write_data;
    action.erase      = 1'b0;
    read_data         = '0;

    unique case (opcode)
      nfc_pkg::OP_READ: begin
        if (busy_now) begin
          read_data = {~poll_bit, 7'b0};
        end else if (id_mode) begin
          read_data = address[0] ? part_code : maker_code;
        end else begin
          read_data = cell_q;
        end
      end
      nfc_pkg::OP_WRITE: begin
        if (!busy_now) begin
          if (unlock_step == nfc_pkg::STEP_PROG) begin
            action.cell_we   = 1'b1;
            poll_bit_next    = write_data[7];
            busy_left_next   = nfc_pkg::TICKS_W'(program_ticks);
            unlock_step_next = nfc_pkg::STEP_IDLE;
          end else if (write_data == nfc_pkg::CMD_ID_EXIT) begin
            id_mode_next     = 1'b0;
            unlock_step_next = nfc_pkg::STEP_IDLE;
          end else begin
            unlock_step_next = nfc_pkg::STEP_IDLE;
            unique case (unlock_step)
              nfc_pkg::STEP_AA: begin
                if (at2 && write_data == nfc_pkg::CMD_UNLOCK_2) begin
                  unlock_step_next = nfc_pkg::STEP_55;
                end
              end
              nfc_pkg::STEP_55: begin
                if (at5 && write_data == nfc_pkg::CMD_ID_ENTRY) begin
                  id_mode_next = 1'b1;
                end else if (at5 && write_data == nfc_pkg::CMD_PROGRAM) begin
                  unlock_step_next = nfc_pkg::STEP_PROG;
                end else if (at5 && write_data == nfc_pkg::CMD_ERASE_SET) begin
                  unlock_step_next = nfc_pkg::STEP_ERASE;
                end
              end
              nfc_pkg::STEP_ERASE: begin
                if (at5 && write_data == nfc_pkg::CMD_UNLOCK_1) begin
                  unlock_step_next = nfc_pkg::STEP_ERASE_AA;
                end
              end
              nfc_pkg::STEP_ERASE_AA: begin
                if (at2 && write_data == nfc_pkg::CMD_UNLOCK_2) begin
                  unlock_step_next = nfc_pkg::STEP_ERASE_55;
                end
              end
              nfc_pkg::STEP_ERASE_55: begin
                if (at5 && write_data == nfc_pkg::CMD_CHIP_ERASE) begin
                  action.erase   = 1'b1;
                  poll_bit_next  = 1'b1;
                  busy_left_next = erase_ticks;
                end
              end
              default: ;
            endcase
            if (unlock_step_next == nfc_pkg::STEP_IDLE && at5 &&
                write_data == nfc_pkg::CMD_UNLOCK_1) begin
              unlock_step_next = nfc_pkg::STEP_AA;
            end
          end
        end
      end
      nfc_pkg::OP_TICK: begin
        if (busy_now) begin
          busy_left_next = busy_left - 1'b1;
        end
      end
      default: ;
    endcase

    busy_res = (busy_left_next != '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      unlock_step <= nfc_pkg::STEP_IDLE;
      id_mode     <= 1'b0;
      busy_left   <= '0;
      poll_bit    <= 1'b0;
    end else if (exec) begin
      unlock_step <= unlock_step_next;
      id_mode     <= id_mode_next;
      busy_left   <= busy_left_next;
      poll_bit    <= poll_bit_next;
    end
  end

endmodule

### sv/parallel_nor_flash_command_model.sv
// ----------------------------------------------------------------------------
// parallel_nor_flash_command_model
// Byte-wide NOR flash with JEDEC command set, cell array in one RAM.
// ----------------------------------------------------------------------------
// Done strobes the result after the start passes the EXEC state and the
// done register. Busy holds off a new transfer until the last is through
// (RAM read, then modify and write back). A chip erase sweeps the RAM to
// 0xFF, one byte a cycle, with busy high. Reset runs the same sweep before
// the first transfer. Results cannot be stalled; done pulses for one cycle.
module parallel_nor_flash_command_model #(
  parameter int ARRAY_BYTES = 131072
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    opcode,
  input  logic [nfc_pkg::ADDR_W-1:0]    address,
  input  logic [nfc_pkg::DATA_W-1:0]    write_data,
  output logic                          done,
  output logic [nfc_pkg::DATA_W-1:0]    read_data,
  output logic                          busy_res,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [1:0]                    cfg_index,
  input  logic [nfc_pkg::TICKS_W-1:0]   cfg_data
);

  localparam int IW = $clog2(ARRAY_BYTES);
  localparam int STEPS = nfc_pkg::ADDR_W - IW + 1;
  localparam int RW = nfc_pkg::ADDR_W + STEPS;

  nfc_pkg::seq_state_t state, state_next;

  logic [IW-1:0]                 sweep_cnt;
  logic [RW-1:0]                 rem;
  logic [IW-1:0]                 in_index;
  logic [IW-1:0]                 item_index;
  logic [1:0]                    item_opcode;
  logic [nfc_pkg::ADDR_W-1:0]    item_address;
  logic [nfc_pkg::DATA_W-1:0]    item_data;

  logic                          ram_we;
  logic [IW-1:0]                 ram_waddr;
  logic [nfc_pkg::DATA_W-1:0]    ram_wdata;
  logic [nfc_pkg::DATA_W-1:0]    ram_rdata;

  nfc_pkg::cell_action_t         action;
  logic [nfc_pkg::DATA_W-1:0]    cmd_read_data;
  logic                          cmd_busy_res;
  logic                          exec;
  logic                          accept;

  assign busy      = (state != nfc_pkg::ST_IDLE);
  assign accept    = start && !busy;
  assign exec      = (state == nfc_pkg::ST_EXEC);
  assign cfg_ready = 1'b1;

  // address wrap: compare-subtract reduction modulo ARRAY_BYTES
  always_comb begin
    rem = RW'(address);
    for (int k = STEPS - 1; k >= 0; k--) begin
      if (rem >= (RW'(ARRAY_BYTES) << k)) begin
        rem = rem - (RW'(ARRAY_BYTES) << k);
      end
    end
    in_index = rem[IW-1:0];
  end

  always_comb begin
    state_next = state;
    unique case (state)
      nfc_pkg::ST_CLEAR: begin
        if (sweep_cnt == IW'(ARRAY_BYTES - 1)) begin
          state_next = nfc_pkg::ST_IDLE;
        end
      end
      nfc_pkg::ST_IDLE: begin
        if (start) begin
          state_next = nfc_pkg::ST_EXEC;
        end
      end
      nfc_pkg::ST_EXEC: begin
        state_next = action.erase ? nfc_pkg::ST_CLEAR : nfc_pkg::ST_IDLE;
      end
      default: state_next = nfc_pkg::ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= nfc_pkg::ST_CLEAR;
      sweep_cnt <= '0;
      done      <= 1'b0;
    end else begin
      state <= state_next;
      done  <= exec;
      if (state == nfc_pkg::ST_CLEAR) begin
        sweep_cnt <= sweep_cnt + 1'b1;
      end else begin
        sweep_cnt <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_index   <= in_index;
      item_opcode  <= opcode;
      item_address <= address;
      item_data    <= write_data;
    end
    if (exec) begin
      read_data <= cmd_read_data;
      busy_res  <= cmd_busy_res;
    end
  end

  always_comb begin
    if (state == nfc_pkg::ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = sweep_cnt;
      ram_wdata = nfc_pkg::ERASED_BYTE;
    end else begin
      ram_we    = exec && action.cell_we;
      ram_waddr = item_index;
      ram_wdata = action.cell_wdata;
    end
  end

  nfc_ram #(
    .WIDTH(nfc_pkg::DATA_W),
    .DEPTH(ARRAY_BYTES)
  ) u_cells (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(in_index),
    .rdata(ram_rdata)
  );

  nfc_cmd u_cmd (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .exec      (exec),
    .opcode    (item_opcode),
    .address   (item_address),
    .write_data(item_data),
    .cell_q    (ram_rdata),
    .action    (action),
    .read_data (cmd_read_data),
    .busy_res  (cmd_busy_res)
  );

endmodule
